// ===== rtl/rcs_pkg.sv =====
package rcs_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LENGTH_BITS = 24;
   localparam int SIZE_BITS   = 32;
   // offset + size + pad + 8 never overflows this
   localparam int SUM_BITS    = 34;
   localparam int HEADER_BYTES = 8;
   localparam int COUNT_BITS  = $clog2(HEADER_BYTES);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX    = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET  = LENGTH_BITS'(65536);
   localparam logic [LENGTH_BITS-1:0] HEADER_LENGTH = LENGTH_BITS'(HEADER_BYTES);

   // four-character codes, first character in the low byte
   localparam logic [31:0] TAG_LIST = 32'h5453_494C;
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_MXOB = 32'h624F_784D;
   localparam logic [31:0] TAG_MXCH = 32'h6843_784D;
   localparam logic [31:0] TAG_MXDA = 32'h6144_784D;
   localparam logic [31:0] TAG_MXST = 32'h7453_784D;
   localparam logic [31:0] TAG_MXHD = 32'h6448_784D;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_ERROR = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef enum logic {
      KIND_OBJECT = 1'b0,
      KIND_STREAM = 1'b1
   } kind_type;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [LENGTH_BITS-1:0] length_type;
   typedef logic [SIZE_BITS-1:0]   size_type;

endpackage

// ===== rtl/rcs_ifs.sv =====
interface rcs_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface rcs_rsp_if import rcs_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   kind_type   chunk_kind;
   offset_type chunk_offset;
   size_type   chunk_size;
   logic       last;

   modport source (output valid, output status, output chunk_kind, output chunk_offset,
                   output chunk_size, output last, input ready);
   modport sink   (input valid, input status, input chunk_kind, input chunk_offset,
                   input chunk_size, input last, output ready);
endinterface

interface rcs_csr_if import rcs_pkg::*; ();
   logic       valid;
   logic       ready;
   length_type buffer_length;

   modport source (output valid, output buffer_length, input ready);
   modport sink   (input valid, input buffer_length, output ready);
endinterface

// ===== rtl/riff_chunk_scanner_unit.sv =====
// RIFF-style chunk header scanner.
// req_if: one buffer byte per beat in memory order; first_byte marks offset 0
//   and restarts the scan. Bytes before any first byte, or after the scan has
//   ended, are dropped without a result.
// rsp_if: at most one beat per input byte, produced when the eighth byte of a
//   header is taken: a data chunk (MxOb/MxCh) with offset and size, an unknown
//   tag error, or end of buffer. last marks the final beat of a buffer scan.
// csr_if: writes buffer_length; always ready. Write only while idle.
// Timing: a result is on rsp_if in the cycle after the header's last byte beat.
// Throughput: one byte per cycle while rsp_if is not stalled; the header
//   judgement (tag decode, 34-bit next-offset add, limit compare) sits between
//   the scan state and the result register.
// A stalled rsp_if holds the result register; req_if stays ready as long as
//   the result register is empty or being drained in the same cycle.
// Reset (synchronous, active high): scan stopped until a first byte,
//   buffer_length = 65536, result register empty.
module riff_chunk_scanner_unit import rcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rcs_req_if.sink   req_if,
   rcs_rsp_if.source rsp_if,
   rcs_csr_if.sink   csr_if
);

   length_type              buf_len_ff;
   offset_type              byte_off_ff, byte_off_in;
   offset_type              next_hdr_ff, next_hdr_in;
   logic [63:0]             shift_ff, shift_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                    running_ff, running_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   kind_type                kind_ff, kind_in;
   offset_type              offset_ff, offset_in;
   size_type                size_ff, size_in;
   logic                    last_ff, last_in;

   logic                    req_fire, load;
   offset_type              here, hdr_at;
   logic [COUNT_BITS-1:0]   cnt;
   logic                    run, take, judge;
   logic [63:0]             header;
   logic [31:0]             tag;
   size_type                size;
   length_type              limit;
   logic [SUM_BITS-1:0]     step, next_sum;
   offset_type              next_sat;
   logic                    past_end;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.chunk_kind   = kind_ff;
   assign rsp_if.chunk_offset = offset_ff;
   assign rsp_if.chunk_size   = size_ff;
   assign rsp_if.last         = last_ff;

   always_comb begin
      here   = req_if.first_byte ? '0 : byte_off_ff;
      hdr_at = req_if.first_byte ? '0 : next_hdr_ff;
      cnt    = req_if.first_byte ? '0 : cnt_ff;
      run    = req_if.first_byte || running_ff;
      take   = run && (here >= hdr_at);
      judge  = take && (cnt == COUNT_BITS'(HEADER_BYTES - 1));
      header = {req_if.data_byte, shift_ff[63:8]};
      tag    = header[31:0];
      size   = header[63:32];
      limit  = (buf_len_ff >= HEADER_LENGTH) ? buf_len_ff - HEADER_LENGTH : '0;

      case (tag) inside
         TAG_LIST, TAG_RIFF: step = SUM_BITS'(12);
         TAG_MXDA, TAG_MXST: step = SUM_BITS'(8);
         TAG_MXHD:           step = SUM_BITS'(size) + SUM_BITS'(8);
         default:            step = SUM_BITS'(size) + SUM_BITS'(size[0]) + SUM_BITS'(8);
      endcase
      next_sum = SUM_BITS'(hdr_at) + step;
      next_sat = (next_sum > SUM_BITS'(OFFSET_MAX)) ? OFFSET_MAX
                                                    : next_sum[OFFSET_BITS-1:0];
      past_end = next_sat > OFFSET_BITS'(limit);
   end

   always_comb begin
      byte_off_in  = byte_off_ff;
      next_hdr_in  = next_hdr_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      running_in   = running_ff;
      load         = 1'b0;
      status_in    = ST_END;
      kind_in      = KIND_OBJECT;
      offset_in    = '0;
      size_in      = '0;
      last_in      = 1'b1;

      if (req_fire) begin
         byte_off_in = (here == OFFSET_MAX) ? OFFSET_MAX : here + 1'b1;
         next_hdr_in = hdr_at;
         cnt_in      = cnt;
         running_in  = run;
         if (take) begin
            shift_in = header;
            cnt_in   = cnt + 1'b1;   // wraps to zero after the eighth byte
         end
         if (judge) begin
            case (tag) inside
               TAG_LIST, TAG_RIFF, TAG_MXDA, TAG_MXST, TAG_MXHD: begin
                  next_hdr_in = next_sat;
                  if (past_end) begin
                     running_in = 1'b0;
                     load       = 1'b1;
                  end
               end
               TAG_MXOB, TAG_MXCH: begin
                  load      = 1'b1;
                  status_in = ST_DATA;
                  kind_in   = (tag == TAG_MXCH) ? KIND_STREAM : KIND_OBJECT;
                  offset_in = hdr_at;
                  size_in   = size;
                  last_in   = past_end;
                  if (past_end) begin
                     running_in = 1'b0;
                  end else begin
                     next_hdr_in = next_sat;
                  end
               end
               default: begin
                  running_in = 1'b0;
                  load       = 1'b1;
                  status_in  = ST_ERROR;
                  offset_in  = hdr_at;
               end
            endcase
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff   <= LENGTH_RESET;
         byte_off_ff  <= '0;
         next_hdr_ff  <= '0;
         shift_ff     <= '0;
         cnt_ff       <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            buf_len_ff <= csr_if.buffer_length;
         end
         byte_off_ff  <= byte_off_in;
         next_hdr_ff  <= next_hdr_in;
         shift_ff     <= shift_in;
         cnt_ff       <= cnt_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
         last_ff   <= last_in;
      end
   end

   // scan only stops together with a final result beat
   a_stop_reports: assert property (@(posedge clock) disable iff (reset)
      $fell(running_ff) && !$past(reset) |-> rsp_valid_ff && last_ff)
      else $error("scan stopped without a last result");

   // a partial header only exists while scanning
   a_count_running: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> running_ff)
      else $error("header byte count nonzero while stopped");

   // error and end beats carry no chunk and always end the scan
   a_nondata_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_DATA |-> last_ff && size_ff == '0
                                               && kind_ff == KIND_OBJECT)
      else $error("non-data result with chunk fields or without last");

   // header position only moves forward within a buffer
   a_next_forward: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_if.first_byte) |=> next_hdr_ff >= $past(next_hdr_ff))
      else $error("next header offset moved backward");

endmodule
